@@ rtl/czl_pkg.sv @@
package czl_pkg;

    localparam int COORD_BITS  = 13;
    localparam int METRIC_BITS = 16;
    // magnitude of (value - min) * 100
    localparam int QUO_BITS    = METRIC_BITS + 7;
    localparam int DIV_CNT_W   = $clog2(QUO_BITS);

    localparam logic [6:0] CNT_MAX     = 7'd127;
    localparam logic [6:0] CU_SIZE_MAX = 7'd64;

    localparam logic [7:0] GREY_LEVEL = 8'd128;
    localparam logic [7:0] GREY_Y     = 8'd126;
    localparam logic [7:0] GREY_UV    = 8'd128;

    localparam logic CFG_METRIC_MIN = 1'b0;
    localparam logic CFG_METRIC_MAX = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0]         ctu_x;
        logic [COORD_BITS-1:0]         ctu_y;
        logic [1:0]                    cu_depth;
        logic signed [METRIC_BITS-1:0] metric_value;
    } t_cu_in;

    typedef struct packed {
        logic [COORD_BITS-1:0] cu_x;
        logic [COORD_BITS-1:0] cu_y;
        logic [6:0]            cu_size;
        logic [7:0]            luma;
        logic [7:0]            chroma_u;
        logic [7:0]            chroma_v;
        logic                  position_overflow;
        logic                  value_out_of_range;
    } t_cu_out;

    typedef struct packed {
        logic [COORD_BITS-1:0]       cu_x;
        logic [COORD_BITS-1:0]       cu_y;
        logic [6:0]                  cu_size;
        logic                        position_overflow;
        logic signed [METRIC_BITS:0] diff;
        logic signed [METRIC_BITS:0] span;
    } t_queue_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_MAP,
        S_EMIT
    } t_back_state;

endpackage

@@ rtl/czl_front.sv @@
module czl_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  czl_pkg::t_cu_in                i_in_data,
    input  logic                           i_q_ready,
    output logic                           o_q_push,
    output czl_pkg::t_queue_entry          o_q_entry,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [czl_pkg::METRIC_BITS-1:0] i_cfg_data
);

    localparam int CB = czl_pkg::COORD_BITS;
    localparam int MB = czl_pkg::METRIC_BITS;

    logic [CB-1:0] r_last_x, r_last_y;
    logic          r_have;
    logic [6:0]    r_cnt [3];
    logic [6:0]    n_cnt [3];
    logic [6:0]    w_cnt [3];
    logic signed [MB-1:0] r_min, r_max;

    logic        w_accept;
    logic        w_new_ctu;
    logic [11:0] w_pos;
    logic        w_ovf;
    logic [5:0]  w_ox, w_oy;
    logic signed [MB:0] w_diff, w_span;

    assign w_accept  = i_in_valid && i_q_ready;
    assign w_new_ctu = !r_have || (i_in_data.ctu_x != r_last_x) || (i_in_data.ctu_y != r_last_y);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_cnt[k] = w_new_ctu ? 7'd0 : r_cnt[k];
        end
    end

    assign w_pos = {1'b0, w_cnt[0], 4'b0} + {3'b0, w_cnt[1], 2'b0} + {5'b0, w_cnt[2]};
    assign w_ovf = (w_pos >= 12'd64);
    assign w_ox  = w_ovf ? 6'd0 : {w_pos[4], w_pos[2], w_pos[0], 3'b0};
    assign w_oy  = w_ovf ? 6'd0 : {w_pos[5], w_pos[3], w_pos[1], 3'b0};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_cnt[k] = w_cnt[k];
            if (!w_ovf && (i_in_data.cu_depth == 2'(k + 1)) && (w_cnt[k] < czl_pkg::CNT_MAX)) begin
                n_cnt[k] = w_cnt[k] + 7'd1;
            end
        end
    end

    assign w_diff = $signed({i_in_data.metric_value[MB-1], i_in_data.metric_value})
                  - $signed({r_min[MB-1], r_min});
    assign w_span = $signed({r_max[MB-1], r_max}) - $signed({r_min[MB-1], r_min});

    always_comb begin
        o_q_entry.cu_x              = i_in_data.ctu_x + CB'(w_ox);
        o_q_entry.cu_y              = i_in_data.ctu_y + CB'(w_oy);
        o_q_entry.cu_size           = czl_pkg::CU_SIZE_MAX >> i_in_data.cu_depth;
        o_q_entry.position_overflow = w_ovf;
        o_q_entry.diff              = w_diff;
        o_q_entry.span              = w_span;
    end

    assign o_q_push = w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x <= '0;
            r_last_y <= '0;
            r_have   <= 1'b0;
            for (int k = 0; k < 3; k++) r_cnt[k] <= '0;
        end else if (w_accept) begin
            r_last_x <= i_in_data.ctu_x;
            r_last_y <= i_in_data.ctu_y;
            r_have   <= 1'b1;
            for (int k = 0; k < 3; k++) r_cnt[k] <= n_cnt[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '0;
            r_max <= MB'(100);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                czl_pkg::CFG_METRIC_MIN: r_min <= i_cfg_data;
                czl_pkg::CFG_METRIC_MAX: r_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/czl_fifo.sv @@
module czl_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  czl_pkg::t_queue_entry i_data,
    output logic                  o_ready,
    output logic                  o_valid,
    output czl_pkg::t_queue_entry o_data,
    input  logic                  i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    czl_pkg::t_queue_entry r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/czl_back.sv @@
module czl_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  czl_pkg::t_queue_entry i_q_entry,
    output logic                  o_q_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output czl_pkg::t_cu_out      o_out_data
);

    localparam int MB  = czl_pkg::METRIC_BITS;
    localparam int QB  = czl_pkg::QUO_BITS;
    localparam int DCW = czl_pkg::DIV_CNT_W;

    typedef enum logic [2:0] {
        B_BLUE_CYAN,
        B_CYAN_GREEN,
        B_GREEN_YELLOW,
        B_YELLOW_RED,
        B_RED
    } t_band;

    czl_pkg::t_back_state r_state, n_state;

    czl_pkg::t_queue_entry r_ent;
    logic          r_neg, r_grey;
    logic [MB-1:0] r_den, r_rem;
    logic [QB-1:0] r_quo;
    logic [DCW-1:0] r_step;
    logic [7:0]    r_red, r_grn, r_blu;
    logic          r_out_valid;
    czl_pkg::t_cu_out r_out;

    logic          w_out_load;
    logic [MB:0]   w_shift;
    logic [MB+1:0] w_trial;
    logic          w_ge;
    logic [MB:0]   w_dmag, w_smag;

    t_band      w_band;
    logic [4:0] w_frac;
    logic [7:0] w_f;
    logic       w_gry;
    logic [7:0] w_red, w_grn, w_blu;

    function automatic logic [7:0] f_yuv(input logic signed [9:0] ca, input logic signed [9:0] cb,
                                         input logic signed [9:0] cc, input logic [7:0] r,
                                         input logic [7:0] g, input logic [7:0] b,
                                         input logic signed [9:0] add);
        logic signed [17:0] acc;
        logic signed [17:0] sh;
        acc = 18'(ca) * $signed({10'b0, r}) + 18'(cb) * $signed({10'b0, g})
            + 18'(cc) * $signed({10'b0, b}) + 18'sd128;
        sh  = (acc >>> 8) + 18'(add);
        if (sh < 0) return 8'd0;
        else if (sh > 18'sd255) return 8'd255;
        else return sh[7:0];
    endfunction

    // control outputs
    always_comb begin
        o_q_pop    = (r_state == czl_pkg::S_IDLE) && i_q_valid;
        w_out_load = (r_state == czl_pkg::S_EMIT) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            czl_pkg::S_IDLE: if (i_q_valid) begin
                n_state = (i_q_entry.span == '0) ? czl_pkg::S_MAP : czl_pkg::S_DIV;
            end
            czl_pkg::S_DIV:  if (r_step == '0) n_state = czl_pkg::S_MAP;
            czl_pkg::S_MAP:  n_state = czl_pkg::S_EMIT;
            czl_pkg::S_EMIT: if (w_out_load) n_state = czl_pkg::S_IDLE;
            default:         n_state = czl_pkg::S_IDLE;
        endcase
    end

    // restoring divider, one quotient bit a cycle
    assign w_shift = {r_rem, r_quo[QB-1]};
    assign w_trial = {1'b0, w_shift} - {2'b0, r_den};
    assign w_ge    = !w_trial[MB+1];

    assign w_dmag = i_q_entry.diff[MB] ? -i_q_entry.diff : i_q_entry.diff;
    assign w_smag = i_q_entry.span[MB] ? -i_q_entry.span : i_q_entry.span;

    always_comb begin
        w_band = B_BLUE_CYAN;
        w_frac = '0;
        w_gry  = r_grey;
        if (r_neg) begin
            if (r_quo > QB'(24)) w_gry = 1'b1;
        end else if (r_quo > QB'(124)) begin
            w_gry = 1'b1;
        end else if (r_quo >= QB'(100)) begin
            w_band = B_RED;
            w_frac = 5'(r_quo - QB'(100));
        end else if (r_quo >= QB'(75)) begin
            w_band = B_YELLOW_RED;
            w_frac = 5'(r_quo - QB'(75));
        end else if (r_quo >= QB'(50)) begin
            w_band = B_GREEN_YELLOW;
            w_frac = 5'(r_quo - QB'(50));
        end else if (r_quo >= QB'(25)) begin
            w_band = B_CYAN_GREEN;
            w_frac = 5'(r_quo - QB'(25));
        end else begin
            w_frac = 5'(r_quo);
        end
    end

    assign w_f = 8'(w_frac) * 8'd10;

    always_comb begin
        w_red = czl_pkg::GREY_LEVEL;
        w_grn = czl_pkg::GREY_LEVEL;
        w_blu = czl_pkg::GREY_LEVEL;
        if (!w_gry) begin
            case (w_band)
                B_BLUE_CYAN:    begin w_red = 8'd0;   w_grn = w_f;          w_blu = 8'd255; end
                B_CYAN_GREEN:   begin w_red = 8'd0;   w_grn = 8'd255;       w_blu = 8'd255 - w_f; end
                B_GREEN_YELLOW: begin w_red = w_f;    w_grn = 8'd255;       w_blu = 8'd0; end
                B_YELLOW_RED:   begin w_red = 8'd255; w_grn = 8'd255 - w_f; w_blu = 8'd0; end
                B_RED:          begin w_red = 8'd255; w_grn = 8'd0;         w_blu = 8'd0; end
                default:        begin w_red = 8'd255; w_grn = 8'd0;         w_blu = 8'd0; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= czl_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            czl_pkg::S_IDLE: if (o_q_pop) begin
                r_ent  <= i_q_entry;
                r_neg  <= i_q_entry.diff[MB] ^ i_q_entry.span[MB];
                r_grey <= (i_q_entry.span == '0);
                r_den  <= w_smag[MB-1:0];
                r_rem  <= '0;
                r_quo  <= QB'(w_dmag[MB-1:0]) * QB'(100);
                r_step <= DCW'(QB - 1);
            end
            czl_pkg::S_DIV: begin
                r_rem  <= w_ge ? w_trial[MB-1:0] : w_shift[MB-1:0];
                r_quo  <= {r_quo[QB-2:0], w_ge};
                r_step <= r_step - DCW'(1);
            end
            czl_pkg::S_MAP: begin
                r_red  <= w_red;
                r_grn  <= w_grn;
                r_blu  <= w_blu;
                r_grey <= w_gry;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.cu_x               <= r_ent.cu_x;
            r_out.cu_y               <= r_ent.cu_y;
            r_out.cu_size            <= r_ent.cu_size;
            r_out.position_overflow  <= r_ent.position_overflow;
            r_out.value_out_of_range <= r_grey;
            r_out.luma     <= f_yuv(10'sd66, 10'sd129, 10'sd25, r_red, r_grn, r_blu, 10'sd16);
            r_out.chroma_u <= f_yuv(-10'sd38, -10'sd74, 10'sd112, r_red, r_grn, r_blu, 10'sd128);
            r_out.chroma_v <= f_yuv(10'sd112, -10'sd94, -10'sd18, r_red, r_grn, r_blu, 10'sd128);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)        r_out_valid <= 1'b0;
        else if (w_out_load) r_out_valid <= 1'b1;
        else if (i_out_ready) r_out_valid <= 1'b0;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/cu_zscan_locator_heat_color_top.sv @@
// Flow: an input transfer goes into the queue; the back end pops it while idle, runs the
//   bit-serial divider unless metric_max equals metric_min, then maps and registers the colour.
// Queueing: the back end pops no new item until its last result is loaded into the output
//   register; the input queue takes QUEUE_DEPTH items ahead of it.
// Reset: synchronous, active low; clears queue, CTU history, depth counters, output
//   valid, and sets metric_min = 0, metric_max = 100.
module cu_zscan_locator_heat_color_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  czl_pkg::t_cu_in                 i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output czl_pkg::t_cu_out                o_out_data,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [czl_pkg::METRIC_BITS-1:0] i_cfg_data
);

    logic                  w_push, w_q_ready, w_q_valid, w_pop;
    czl_pkg::t_queue_entry w_push_entry, w_pop_entry;

    czl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_q_ready  (w_q_ready),
        .o_q_push   (w_push),
        .o_q_entry  (w_push_entry),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    czl_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_entry),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_data  (w_pop_entry),
        .i_pop   (w_pop)
    );

    czl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_entry   (w_pop_entry),
        .o_q_pop     (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    assign o_in_ready = w_q_ready;

endmodule

@@ rtl/czl_checker.sv @@
module czl_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input czl_pkg::t_cu_out o_out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_size_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.cu_size == 7'd64 || o_out_data.cu_size == 7'd32 ||
                         o_out_data.cu_size == 7'd16 || o_out_data.cu_size == 7'd8))
        else $error("illegal cu_size");

    // grey flag must come with the YUV of grey
    a_grey_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.value_out_of_range |->
            o_out_data.luma == czl_pkg::GREY_Y && o_out_data.chroma_u == czl_pkg::GREY_UV &&
            o_out_data.chroma_v == czl_pkg::GREY_UV)
        else $error("grey flag with wrong color");

    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_rst_ready: assert property (@(posedge i_clk) !i_rst_n |=> o_in_ready)
        else $error("queue not empty after reset");

endmodule

bind cu_zscan_locator_heat_color_top czl_checker u_checker (.*);

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;

    localparam int CB           = czl_pkg::COORD_BITS;
    localparam int MB           = czl_pkg::METRIC_BITS;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_CUS    = 205;
    localparam int MAX_WAIT     = 12;
    localparam int NUM_PHASES   = 8;

    typedef enum logic [1:0] {
        ROW_CU,
        ROW_CU_KNOWN,
        ROW_BOUND
    } t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        czl_pkg::t_cu_in  cu;
        czl_pkg::t_cu_out want;
        logic             bound_idx;
        logic [MB-1:0]    bound_val;
    } t_row;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    czl_pkg::t_cu_in  in_data   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    czl_pkg::t_cu_out out_data;
    logic             cfg_we    = 1'b0;
    logic             cfg_idx   = 1'b0;
    logic [MB-1:0]    cfg_data  = '0;

    // predictor state
    logic signed [MB-1:0] bound_min = 16'sd0;
    logic signed [MB-1:0] bound_max = 16'sd100;
    logic [CB-1:0]        prev_ctu_x;
    logic [CB-1:0]        prev_ctu_y;
    bit                   ctu_seen;
    int                   depth_cnt[3];

    t_row             dir_rows[$];
    t_row             stim_q[$];
    czl_pkg::t_cu_out pending_cu[$];

    int mismatch_cnt = 0;
    int cycle_cnt    = 0;
    bit hold_req     = 1'b0;
    int send_left    = 0;
    bit send_calm    = 1'b0;
    int recv_left    = 0;
    bit recv_calm    = 1'b0;

    cu_zscan_locator_heat_color_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int yuv_term(int kr, int kg, int kb, int r, int g, int b, int ofs);
        int acc;
        acc = ((kr * r + kg * g + kb * b + 128) >>> 8) + ofs;
        if (acc > 255)
            acc = 255;
        else if (acc < 0)
            acc = 0;
        return acc;
    endfunction

    // z-scan placement plus heat ramp; advances the per-CTU depth counters
    function automatic czl_pkg::t_cu_out locate_and_color(czl_pkg::t_cu_in cu);
        czl_pkg::t_cu_out res;
        int      pos, ox, oy, r, g, b, d;
        longint  v, span, n, seg, frac;
        bit      grey;
        d = int'(cu.cu_depth);
        if (!ctu_seen || cu.ctu_x != prev_ctu_x || cu.ctu_y != prev_ctu_y) begin
            for (int i = 0; i < 3; i++)
                depth_cnt[i] = 0;
        end
        prev_ctu_x = cu.ctu_x;
        prev_ctu_y = cu.ctu_y;
        ctu_seen   = 1'b1;

        pos = depth_cnt[0] * 16 + depth_cnt[1] * 4 + depth_cnt[2];
        ox  = 0;
        oy  = 0;
        res.position_overflow = (pos >= 64);
        if (pos < 64) begin
            ox = (pos[0] ? 8 : 0) + (pos[2] ? 16 : 0) + (pos[4] ? 32 : 0);
            oy = (pos[1] ? 8 : 0) + (pos[3] ? 16 : 0) + (pos[5] ? 32 : 0);
            if (d != 0 && depth_cnt[d-1] < int'(czl_pkg::CNT_MAX))
                depth_cnt[d-1]++;
        end
        res.cu_x    = CB'(int'(cu.ctu_x) + ox);
        res.cu_y    = CB'(int'(cu.ctu_y) + oy);
        res.cu_size = czl_pkg::CU_SIZE_MAX >> d;

        grey = 1'b0;
        r    = 0;
        g    = 0;
        b    = 0;
        span = longint'(bound_max) - longint'(bound_min);
        if (span == 0) begin
            grey = 1'b1;
        end else begin
            v    = longint'($signed(cu.metric_value));
            n    = ((v - longint'(bound_min)) * 100) / span;
            seg  = n / 25;
            frac = 10 * (n % 25);
            if (frac < 0)
                frac = 0;
            case (seg)
                0: begin
                    r = 0; g = int'(frac); b = 255;
                end
                1: begin
                    r = 0; g = 255; b = 255 - int'(frac);
                end
                2: begin
                    r = int'(frac); g = 255; b = 0;
                end
                3: begin
                    r = 255; g = 255 - int'(frac); b = 0;
                end
                4: begin
                    r = 255; g = 0; b = 0;
                end
                default: grey = 1'b1;
            endcase
        end
        if (grey) begin
            r = int'(czl_pkg::GREY_LEVEL);
            g = int'(czl_pkg::GREY_LEVEL);
            b = int'(czl_pkg::GREY_LEVEL);
        end
        res.luma               = 8'(yuv_term(66, 129, 25, r, g, b, 16));
        res.chroma_u           = 8'(yuv_term(-38, -74, 112, r, g, b, 128));
        res.chroma_v           = 8'(yuv_term(112, -94, -18, r, g, b, 128));
        res.value_out_of_range = grey;
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatch_cnt++;
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch(name, got, want);
    endtask

    task automatic compare_cu(czl_pkg::t_cu_out got);
        czl_pkg::t_cu_out want;
        if (pending_cu.size() == 0) begin
            report_mismatch("result with nothing pending, cu_x", int'(got.cu_x), -1);
            return;
        end
        want = pending_cu.pop_front();
        check_field("cu_x", int'(got.cu_x), int'(want.cu_x));
        check_field("cu_y", int'(got.cu_y), int'(want.cu_y));
        check_field("cu_size", int'(got.cu_size), int'(want.cu_size));
        check_field("luma", int'(got.luma), int'(want.luma));
        check_field("chroma_u", int'(got.chroma_u), int'(want.chroma_u));
        check_field("chroma_v", int'(got.chroma_v), int'(want.chroma_v));
        check_field("position_overflow", int'(got.position_overflow),
                    int'(want.position_overflow));
        check_field("value_out_of_range", int'(got.value_out_of_range),
                    int'(want.value_out_of_range));
    endtask

    // random wait per transfer, with calm stretches where nothing idles
    function automatic int next_wait(inout int left, inout bit calm);
        if (left == 0) begin
            left = int'($urandom_range(8, 40));
            calm = ($urandom_range(0, 3) == 0);
        end
        left--;
        return calm ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    function automatic t_row cu_row(int x, int y, int d, int v);
        t_row row;
        row                 = '0;
        row.kind            = ROW_CU;
        row.cu.ctu_x        = CB'(x);
        row.cu.ctu_y        = CB'(y);
        row.cu.cu_depth     = 2'(d);
        row.cu.metric_value = MB'(v);
        return row;
    endfunction

    function automatic t_row known_row(int x, int y, int d, int v, int cx, int cy, int size,
                                       int lum, int cu, int cv, bit ovf, bit grey);
        t_row row;
        row                         = cu_row(x, y, d, v);
        row.kind                    = ROW_CU_KNOWN;
        row.want.cu_x               = CB'(cx);
        row.want.cu_y               = CB'(cy);
        row.want.cu_size            = 7'(size);
        row.want.luma               = 8'(lum);
        row.want.chroma_u           = 8'(cu);
        row.want.chroma_v           = 8'(cv);
        row.want.position_overflow  = ovf;
        row.want.value_out_of_range = grey;
        return row;
    endfunction

    function automatic t_row bound_row(logic idx, int val);
        t_row row;
        row           = '0;
        row.kind      = ROW_BOUND;
        row.bound_idx = idx;
        row.bound_val = MB'(val);
        return row;
    endfunction

    task automatic write_bound(logic idx, logic [MB-1:0] val);
        while (pending_cu.size() != 0)
            @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == czl_pkg::CFG_METRIC_MIN)
            bound_min = val;
        else
            bound_max = val;
        @(posedge clk);
    endtask

    task automatic send_cus();
        t_row             row;
        czl_pkg::t_cu_out pred;
        int               gap;
        while (stim_q.size() != 0) begin
            row = stim_q.pop_front();
            gap = next_wait(send_left, send_calm);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_data  <= row.cu;
            in_valid <= 1'b1;
            @(negedge clk);
            while (!in_ready)
                @(negedge clk);
            @(posedge clk);
            // transfer at this edge
            pred = locate_and_color(row.cu);
            if (row.kind == ROW_CU_KNOWN)
                pred = row.want;
            pending_cu = {pending_cu, pred};
        end
        in_valid <= 1'b0;
    endtask

    // mostly within the ramp, some metrics anywhere
    function automatic int pick_metric();
        longint span, v;
        if ($urandom_range(0, 3) == 0)
            return int'($urandom_range(0, 65535)) - 32768;
        span = longint'(bound_max) - longint'(bound_min);
        v    = longint'(bound_min) + (span * (longint'($urandom_range(0, 1300)) - 150)) / 1000;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return int'(v);
    endfunction

    // runs of CUs inside one CTU, with lone CUs from scattered CTUs mixed in
    task automatic fill_random_cus(int n);
        int made, run, x, y;
        made = 0;
        while (made < n) begin
            x = int'($urandom_range(0, 8191));
            y = int'($urandom_range(0, 8191));
            if ($urandom_range(0, 1) == 0) begin
                x = x & ~63;
                y = y & ~63;
            end
            run = ($urandom_range(0, 7) == 0) ? 1 : int'($urandom_range(4, 30));
            repeat (run) begin
                stim_q = {stim_q, cu_row(x, y, int'($urandom_range(0, 3)), pick_metric())};
                made++;
            end
        end
    endtask

    initial begin : result_sink
        czl_pkg::t_cu_out got;
        int               stall;
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end else begin
                stall = next_wait(recv_left, recv_calm);
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(negedge clk);
            while (!out_valid)
                @(negedge clk);
            got = out_data;
            @(posedge clk);
            compare_cu(got);
        end
    end

    initial begin : stimulus
        t_row          row;
        logic [MB-1:0] lo, hi;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset bounds 0..100: blue is 41/240/110, red is 82/90/240
        dir_rows = {dir_rows, known_row(0, 0, 0, 0, 0, 0, 64, 41, 240, 110, 0, 0)};
        dir_rows = {dir_rows, known_row(0, 0, 0, 100, 0, 0, 64, 82, 90, 240, 0, 0)};
        dir_rows = {dir_rows, known_row(0, 0, 0, 125, 0, 0, 64, int'(czl_pkg::GREY_Y),
                                        int'(czl_pkg::GREY_UV), int'(czl_pkg::GREY_UV), 0, 1)};
        // slightly below min still lands on blue
        dir_rows = {dir_rows, known_row(0, 0, 0, -1, 0, 0, 64, 41, 240, 110, 0, 0)};
        dir_rows = {dir_rows, known_row(0, 0, 0, -25, 0, 0, 64, int'(czl_pkg::GREY_Y),
                                        int'(czl_pkg::GREY_UV), int'(czl_pkg::GREY_UV), 0, 1)};
        dir_rows = {dir_rows, cu_row(0, 0, 0, 32767)};
        dir_rows = {dir_rows, cu_row(0, 0, 0, -32768)};
        // walk the z-scan of one CTU until the position overflows
        dir_rows = {dir_rows, cu_row(64, 128, 1, 50)};
        dir_rows = {dir_rows, cu_row(64, 128, 1, 37)};
        dir_rows = {dir_rows, cu_row(64, 128, 2, 12)};
        dir_rows = {dir_rows, cu_row(64, 128, 3, 88)};
        dir_rows = {dir_rows, cu_row(64, 128, 1, 63)};
        dir_rows = {dir_rows, cu_row(64, 128, 1, 75)};
        dir_rows = {dir_rows, cu_row(64, 128, 3, 99)};
        dir_rows = {dir_rows, cu_row(64, 128, 2, 20)};
        // CU origin wraps past the top coordinate
        dir_rows = {dir_rows, cu_row(8191, 8191, 3, 0)};
        dir_rows = {dir_rows, cu_row(8191, 8191, 3, 1)};
        dir_rows = {dir_rows, cu_row(8191, 8191, 2, 2)};
        dir_rows = {dir_rows, cu_row('h1555, 'h0aaa, 2, 'h5555)};
        // equal bounds give grey
        dir_rows = {dir_rows, bound_row(czl_pkg::CFG_METRIC_MIN, 500)};
        dir_rows = {dir_rows, bound_row(czl_pkg::CFG_METRIC_MAX, 500)};
        dir_rows = {dir_rows, known_row(0, 0, 0, 500, 0, 0, 64, int'(czl_pkg::GREY_Y),
                                        int'(czl_pkg::GREY_UV), int'(czl_pkg::GREY_UV), 0, 1)};
        dir_rows = {dir_rows, cu_row(0, 0, 3, -32768)};
        // reversed bounds
        dir_rows = {dir_rows, bound_row(czl_pkg::CFG_METRIC_MIN, 100)};
        dir_rows = {dir_rows, bound_row(czl_pkg::CFG_METRIC_MAX, -100)};
        dir_rows = {dir_rows, cu_row(0, 0, 3, 0)};
        dir_rows = {dir_rows, cu_row(0, 0, 3, -100)};
        dir_rows = {dir_rows, cu_row(0, 0, 3, 150)};
        // widest span
        dir_rows = {dir_rows, bound_row(czl_pkg::CFG_METRIC_MIN, -32768)};
        dir_rows = {dir_rows, bound_row(czl_pkg::CFG_METRIC_MAX, 32767)};
        dir_rows = {dir_rows, cu_row(0, 0, 0, 32767)};
        dir_rows = {dir_rows, cu_row(0, 0, 0, -32768)};

        for (int i = 0; i < dir_rows.size(); i++) begin
            row = dir_rows[i];
            if (row.kind == ROW_BOUND) begin
                send_cus();
                write_bound(row.bound_idx, row.bound_val);
            end else begin
                stim_q = {stim_q, row};
            end
        end
        send_cus();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    lo = 16'h8000; hi = 16'h7fff;
                end
                1: begin
                    lo = 16'h7fff; hi = 16'h8000;
                end
                2: begin
                    lo = MB'($urandom); hi = lo;
                end
                3: begin
                    lo = 16'd0; hi = 16'd1;
                end
                default: begin
                    lo = MB'($urandom); hi = MB'($urandom);
                end
            endcase
            write_bound(czl_pkg::CFG_METRIC_MIN, lo);
            write_bound(czl_pkg::CFG_METRIC_MAX, hi);
            // sink stalls long enough to back up the input queue
            if (phase == 1)
                hold_req = 1'b1;
            fill_random_cus(PHASE_CUS);
            send_cus();
        end

        while (pending_cu.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
